FILE: rtl/mcrl_pkg.sv
// ----------------------------------------------------------------------------
// mcrl_pkg
// Shared types and constants for the multi-channel ring log.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrl_pkg;

  localparam int unsigned MEM_BYTES    = 1024;
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned MEM_AW       = $clog2(MEM_BYTES);
  localparam int unsigned CHAN_SLOTS   = 4;
  localparam int unsigned DESC_W       = 17;
  localparam int unsigned SUM_W        = 18;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_MISSING  = 2'd2,
    STATUS_DISABLED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CALC,
    BK_ADDR,
    BK_MEM,
    BK_RESP
  } back_state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [1:0]        channel;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [7:0]        entry;
    logic [7:0]        byte_offset;
    logic              chan_ok;
    logic              in_range;
    logic              overwrite;
    logic [7:0]        block_bytes;
    logic [7:0]        block_count;
    logic [MEM_AW-1:0] base;
  } item_t;

  typedef struct packed {
    logic       clear;
    logic [1:0] channel;
  } cfg_clear_t;

endpackage

`default_nettype wire

FILE: rtl/mcrl_ram.sv
// ----------------------------------------------------------------------------
// mcrl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/mcrl_front.sv
// ----------------------------------------------------------------------------
// mcrl_front
// Descriptor registers, region layout and command classification.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [mcrl_pkg::DESC_W-1:0] cfg_wdata_i,
  input  wire logic                       start_i,
  input  wire logic                       full_i,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic [1:0]                 channel_i,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic                       last_byte_i,
  input  wire logic [7:0]                 entry_i,
  input  wire logic [7:0]                 byte_offset_i,
  output logic                            push_o,
  output logic                            busy_o,
  output mcrl_pkg::item_t                 item_o,
  output mcrl_pkg::cfg_clear_t            cfg_clear_o
);

  import mcrl_pkg::*;

  logic [DESC_W-1:0] desc_q [CHAN_SLOTS];
  logic [15:0]       size_q [CHAN_SLOTS];
  logic [SUM_W-1:0]  base_sum;
  logic [SUM_W-1:0]  end_sum;
  logic [DESC_W-1:0] desc;
  logic              in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHAN_SLOTS; i++) begin
        desc_q[i] <= '0;
        size_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      desc_q[cfg_idx_i] <= cfg_wdata_i;
      size_q[cfg_idx_i] <= 16'(cfg_wdata_i[7:0]) * 16'(cfg_wdata_i[15:8]);
    end
  end

  // region base: sum of lower channel sizes
  always_comb begin
    base_sum = '0;
    for (int j = 0; j < CHAN_SLOTS; j++) begin
      if (32'(j) < 32'(channel_i)) begin
        base_sum = base_sum + SUM_W'(size_q[j]);
      end
    end
  end

  assign end_sum  = base_sum + SUM_W'(size_q[channel_i]);
  assign desc     = desc_q[channel_i];
  assign in_range = 32'(channel_i) < NUM_CHANNELS;

  always_comb begin
    item_o.cmd         = cmd_e'(cmd_i);
    item_o.channel     = channel_i;
    item_o.data_byte   = data_byte_i;
    item_o.last_byte   = last_byte_i;
    item_o.entry       = entry_i;
    item_o.byte_offset = byte_offset_i;
    item_o.in_range    = in_range;
    item_o.overwrite   = desc[16];
    item_o.block_bytes = desc[7:0];
    item_o.block_count = desc[15:8];
    item_o.base        = base_sum[MEM_AW-1:0];
    item_o.chan_ok     = in_range && (desc[7:0] != 8'd0) && (desc[15:8] != 8'd0) &&
                         (end_sum <= SUM_W'(MEM_BYTES));
  end

  assign push_o              = start_i && !full_i;
  assign busy_o              = full_i;
  assign cfg_clear_o.clear   = cfg_we_i;
  assign cfg_clear_o.channel = cfg_idx_i;

endmodule

`default_nettype wire

FILE: rtl/mcrl_queue.sv
// ----------------------------------------------------------------------------
// mcrl_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  mcrl_pkg::item_t       item_i,
  input  wire logic             pop_i,
  output mcrl_pkg::item_t       item_o,
  output logic                  empty_o,
  output logic                  full_o
);

  import mcrl_pkg::*;

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcrl_back.sv
// ----------------------------------------------------------------------------
// mcrl_back
// Pointer state, slot/address sequencer and byte memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  mcrl_pkg::item_t       item_i,
  input  mcrl_pkg::cfg_clear_t  cfg_clear_i,
  output logic                  pop_o,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [7:0]            read_byte_o,
  output logic [7:0]            stored_blocks_o
);

  import mcrl_pkg::*;

  back_state_e       state_q, state_d;
  item_t             cur_q;
  logic [7:0]        next_slot_q [CHAN_SLOTS];
  logic [7:0]        next_slot_d [CHAN_SLOTS];
  logic [7:0]        filled_q    [CHAN_SLOTS];
  logic [7:0]        filled_d    [CHAN_SLOTS];
  logic [7:0]        wpos_q, wpos_d;
  logic              acc_q, acc_d;
  status_e           status_q, status_d;
  logic [7:0]        stored_q, stored_d;
  logic              wr_q, wr_d, rd_q, rd_d;
  logic [7:0]        slot_q, slot_d, pos_q, pos_d;
  logic [MEM_AW-1:0] addr_q;
  logic [SUM_W-1:0]  addr_sum;
  logic [15:0]       slot_off;
  logic [7:0]        ram_rdata;

  logic [1:0]        ch;
  logic [7:0]        cnt, held, slot, slot_inc, slot_next, held_inc, filled_new;
  logic [8:0]        oldest, pick, sel;
  logic              acc_eff;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    done_o  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_CALC;
        end
      end
      BK_CALC: state_d = BK_ADDR;
      BK_ADDR: state_d = BK_MEM;
      BK_MEM:  state_d = BK_RESP;
      BK_RESP: begin
        done_o = 1'b1;
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_CALC;
        end else begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // slot arithmetic
  assign ch        = cur_q.channel;
  assign cnt       = cur_q.block_count;
  assign held      = (filled_q[ch] > cnt) ? cnt : filled_q[ch];
  assign slot      = next_slot_q[ch];
  assign slot_inc  = slot + 8'd1;
  assign slot_next = (slot_inc == cnt) ? 8'd0 : slot_inc;
  assign held_inc  = (held < cnt) ? held + 8'd1 : cnt;
  assign oldest    = (slot >= held) ? {1'b0, slot} - {1'b0, held}
                                    : {1'b0, slot} + {1'b0, cnt} - {1'b0, held};
  assign pick      = oldest + {1'b0, cur_q.entry};
  assign sel       = (pick >= {1'b0, cnt}) ? pick - {1'b0, cnt} : pick;
  assign acc_eff   = (wpos_q == 8'd0) ? !((held >= cnt) && !cur_q.overwrite) : acc_q;

  always_comb begin
    next_slot_d = next_slot_q;
    filled_d    = filled_q;
    wpos_d      = wpos_q;
    acc_d       = acc_q;
    status_d    = STATUS_OK;
    wr_d        = 1'b0;
    rd_d        = 1'b0;
    slot_d      = slot;
    pos_d       = wpos_q;
    filled_new  = filled_q[ch];
    if (state_q == BK_CALC) begin
      case (cur_q.cmd)
        CMD_WRITE: begin
          if (!cur_q.chan_ok) begin
            status_d = STATUS_DISABLED;
            if (cur_q.last_byte) begin
              wpos_d = 8'd0;
              acc_d  = 1'b0;
            end
          end else begin
            acc_d = acc_eff;
            if (!acc_eff) begin
              status_d = STATUS_FULL;
            end else if (wpos_q < cur_q.block_bytes) begin
              wr_d = 1'b1;
            end else begin
              status_d = STATUS_MISSING;
            end
            if (wpos_q != 8'hFF) begin
              wpos_d = wpos_q + 8'd1;
            end
            if (cur_q.last_byte) begin
              if (acc_eff) begin
                next_slot_d[ch] = slot_next;
                filled_new      = held_inc;
              end
              wpos_d = 8'd0;
              acc_d  = 1'b0;
            end
          end
        end
        CMD_READ: begin
          pos_d = cur_q.byte_offset;
          if (!cur_q.chan_ok) begin
            status_d = STATUS_DISABLED;
          end else if ((cur_q.entry >= held) || (cur_q.byte_offset >= cur_q.block_bytes)) begin
            status_d = STATUS_MISSING;
          end else begin
            rd_d   = 1'b1;
            slot_d = sel[7:0];
          end
        end
        CMD_CLEAR: begin
          next_slot_d[ch] = 8'd0;
          filled_new      = 8'd0;
          wpos_d          = 8'd0;
          acc_d           = 1'b0;
        end
        default: ;
      endcase
      filled_d[ch] = filled_new;
    end
    // descriptor write restarts the channel
    if (cfg_clear_i.clear) begin
      next_slot_d[cfg_clear_i.channel] = 8'd0;
      filled_d[cfg_clear_i.channel]    = 8'd0;
    end
  end

  assign stored_d = !cur_q.in_range ? 8'd0 : ((filled_new > cnt) ? cnt : filled_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHAN_SLOTS; i++) begin
        next_slot_q[i] <= '0;
        filled_q[i]    <= '0;
      end
      wpos_q <= '0;
      acc_q  <= 1'b0;
    end else begin
      next_slot_q <= next_slot_d;
      filled_q    <= filled_d;
      wpos_q      <= wpos_d;
      acc_q       <= acc_d;
    end
  end

  assign slot_off = 16'(slot_q) * 16'(cur_q.block_bytes);
  assign addr_sum = SUM_W'(cur_q.base) + SUM_W'(slot_off) + SUM_W'(pos_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == BK_CALC) begin
      status_q <= status_d;
      stored_q <= stored_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      slot_q   <= slot_d;
      pos_q    <= pos_d;
    end
    if (state_q == BK_ADDR) begin
      addr_q <= addr_sum[MEM_AW-1:0];
    end
  end

  mcrl_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_log_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == BK_MEM) && wr_q),
    .addr_i  (addr_q),
    .wdata_i (cur_q.data_byte),
    .rdata_o (ram_rdata)
  );

  assign status_o        = status_q;
  assign read_byte_o     = rd_q ? ram_rdata : 8'd0;
  assign stored_blocks_o = stored_q;

endmodule

`default_nettype wire

FILE: rtl/multi_channel_ring_log.sv
// ----------------------------------------------------------------------------
// multi_channel_ring_log
// Circular block log with up to four channels sharing one byte memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and gives exactly one
// result beat: done_o is high for one cycle with status_o, read_byte_o and
// stored_blocks_o, and the receiver must take it then. The back sequencer
// takes each item through slot arithmetic, an address multiply-add, one
// access of the single-port byte memory and read data out, one item at a
// time. A two-entry queue sits in front of the sequencer and takes new
// items meanwhile; busy is high while it is full. Descriptors are to be
// written only while the block is idle, which the block itself does not
// enforce, and a descriptor write clears that channel's stored blocks.
`default_nettype none

module multi_channel_ring_log (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [1:0]                  channel_i,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        last_byte_i,
  input  wire logic [7:0]                  entry_i,
  input  wire logic [7:0]                  byte_offset_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [mcrl_pkg::DESC_W-1:0] cfg_wdata_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [7:0]                       read_byte_o,
  output logic [7:0]                       stored_blocks_o
);

  import mcrl_pkg::*;

  item_t      front_item, queue_item;
  cfg_clear_t cfg_clear;
  logic       push, pop, q_empty, q_full;

  mcrl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start),
    .full_i        (q_full),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .entry_i       (entry_i),
    .byte_offset_i (byte_offset_i),
    .push_o        (push),
    .busy_o        (busy),
    .item_o        (front_item),
    .cfg_clear_o   (cfg_clear)
  );

  mcrl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mcrl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .item_i          (queue_item),
    .cfg_clear_i     (cfg_clear),
    .pop_o           (pop),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .stored_blocks_o (stored_blocks_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mcrl_checker.sv
// ----------------------------------------------------------------------------
// mcrl_checker
// Port-level checks for the multi-channel ring log, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic [7:0] read_byte_o
);

  import mcrl_pkg::*;

  // result beats are single-cycle and never back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("back-to-back result beats");

  // fetched data only comes with a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_byte_o != 8'd0)) |-> (status_o == STATUS_OK))
    else $error("read data on failed beat");

  // reset leaves no result and an empty queue
  assert property (@(posedge clk_i) !rst_ni |-> (!done_o && !busy))
    else $error("activity during reset");

endmodule

bind multi_channel_ring_log mcrl_checker u_mcrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .done_o      (done_o),
  .status_o    (status_o),
  .read_byte_o (read_byte_o)
);

`default_nettype wire

FILE: tb/sv/multi_channel_ring_log_test.sv
// ----------------------------------------------------------------------------
// multi_channel_ring_log_test
// Self-checking testbench for the multi-channel ring log.
// ----------------------------------------------------------------------------
// Tracks which memory bytes have been written. A read that would fetch a byte
// not yet written is sent with an entry past the stored blocks. Runs directed
// cases and write-position saturation, then sweeps several channel layouts
// with block-structured random traffic. The last stretch runs with no idle
// cycles. A local predictor models the channel pointers and the memory. Each
// result beat is compared with the oldest predicted reply.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_ring_log_test;
  import mcrl_pkg::*;

  localparam int unsigned RESULT_LATENCY = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {
    REG_CHAN0_DESC = 2'd0,
    REG_CHAN1_DESC = 2'd1,
    REG_CHAN2_DESC = 2'd2,
    REG_CHAN3_DESC = 2'd3
  } desc_reg_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] entry;
    logic [7:0] byte_offset;
  } log_cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_byte;
    logic [7:0] stored_blocks;
  } log_reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        cmd_i;
  logic [1:0]        channel_i;
  logic [7:0]        data_byte_i;
  logic              last_byte_i;
  logic [7:0]        entry_i;
  logic [7:0]        byte_offset_i;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [DESC_W-1:0] cfg_wdata_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [7:0]        read_byte_o;
  logic [7:0]        stored_blocks_o;

  // predictor state
  logic [DESC_W-1:0] chan_desc   [4];
  logic [7:0]        log_mem     [MEM_BYTES];
  bit                log_written [MEM_BYTES];
  logic [7:0]        slot_ptr    [4];
  logic [7:0]        fill_level  [4];
  logic [7:0]        byte_pos;
  logic              block_taken;

  log_reply_t  pending_replies [$];
  log_reply_t  want;
  int unsigned mismatches   = 0;
  int unsigned replies_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  int unsigned quiet_items  = 0;
  bit          idle_gaps    = 1'b1;

  multi_channel_ring_log dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .channel_i       (channel_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .entry_i         (entry_i),
    .byte_offset_i   (byte_offset_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .stored_blocks_o (stored_blocks_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DESC_W-1:0] desc_value(input int unsigned nbytes,
                                                   input int unsigned nblocks,
                                                   input bit ow);
    return {ow, 8'(nblocks), 8'(nbytes)};
  endfunction

  function automatic bit region_of(input int unsigned ch, output int unsigned base,
                                   output int unsigned nbytes, output int unsigned nblocks);
    base = 0;
    for (int unsigned j = 0; j < ch; j++)
      base += 32'(chan_desc[j][7:0]) * 32'(chan_desc[j][15:8]);
    nbytes  = chan_desc[ch][7:0];
    nblocks = chan_desc[ch][15:8];
    return ch < NUM_CHANNELS && nbytes != 0 && nblocks != 0 &&
           base + nbytes * nblocks <= MEM_BYTES;
  endfunction

  function automatic int unsigned held_blocks(input int unsigned ch);
    return fill_level[ch] > chan_desc[ch][15:8] ? chan_desc[ch][15:8] : fill_level[ch];
  endfunction

  // false only for a read that would fetch a byte never written
  function automatic bit read_defined(input log_cmd_t c);
    int unsigned base, nbytes, nblocks, held, slot, oldest;
    if (c.cmd != CMD_READ || !region_of(c.channel, base, nbytes, nblocks))
      return 1'b1;
    held = held_blocks(c.channel);
    if (c.entry >= held || c.byte_offset >= nbytes)
      return 1'b1;
    slot   = slot_ptr[c.channel] % nblocks;
    oldest = (slot + nblocks - held) % nblocks;
    return log_written[base + ((oldest + c.entry) % nblocks) * nbytes + c.byte_offset];
  endfunction

  function automatic log_reply_t predict_reply(input log_cmd_t c);
    int unsigned base, nbytes, nblocks, held, slot, oldest, addr;
    bit          ok;
    log_reply_t  r;
    ok   = region_of(c.channel, base, nbytes, nblocks);
    held = held_blocks(c.channel);
    r.status    = STATUS_OK;
    r.read_byte = '0;
    case (c.cmd)
      CMD_WRITE: begin
        if (!ok) begin
          r.status = STATUS_DISABLED;
          if (c.last_byte) begin
            byte_pos    = '0;
            block_taken = 1'b0;
          end
        end else begin
          slot = slot_ptr[c.channel] % nblocks;
          if (byte_pos == 0)
            block_taken = !(held >= nblocks && !chan_desc[c.channel][16]);
          if (!block_taken) begin
            r.status = STATUS_FULL;
          end else if (byte_pos < nbytes) begin
            addr              = base + slot * nbytes + byte_pos;
            log_mem[addr]     = c.data_byte;
            log_written[addr] = 1'b1;
          end else begin
            r.status = STATUS_MISSING;
          end
          if (byte_pos != 8'hFF)
            byte_pos++;
          if (c.last_byte) begin
            if (block_taken) begin
              slot_ptr[c.channel]   = 8'((slot + 1) % nblocks);
              fill_level[c.channel] = 8'(held < nblocks ? held + 1 : nblocks);
            end
            byte_pos    = '0;
            block_taken = 1'b0;
          end
        end
      end
      CMD_READ: begin
        if (!ok) begin
          r.status = STATUS_DISABLED;
        end else if (c.entry >= held || c.byte_offset >= nbytes) begin
          r.status = STATUS_MISSING;
        end else begin
          slot   = slot_ptr[c.channel] % nblocks;
          oldest = (slot + nblocks - held) % nblocks;
          r.read_byte = log_mem[base + ((oldest + c.entry) % nblocks) * nbytes + c.byte_offset];
        end
      end
      CMD_CLEAR: begin
        slot_ptr[c.channel]   = '0;
        fill_level[c.channel] = '0;
        byte_pos              = '0;
        block_taken           = 1'b0;
      end
      default: ;
    endcase
    r.stored_blocks = 8'(held_blocks(c.channel));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // one beat per call; start stays high into the next call unless a gap is drawn
  task automatic post_command(input cmd_e cmd, input logic [1:0] ch, input logic [7:0] data,
                              input logic last, input logic [7:0] entry,
                              input logic [7:0] offs);
    log_cmd_t c;
    c = '{cmd, ch, data, last, entry, offs};
    if (!read_defined(c))
      c.entry = 8'hFF;
    if (idle_gaps && quiet_items == 0 && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      if ($urandom_range(0, 7) == 0)
        quiet_items = $urandom_range(10, 40);
    end else if (quiet_items != 0) begin
      quiet_items--;
    end
    start         <= 1'b1;
    cmd_i         <= c.cmd;
    channel_i     <= c.channel;
    data_byte_i   <= c.data_byte;
    last_byte_i   <= c.last_byte;
    entry_i       <= c.entry;
    byte_offset_i <= c.byte_offset;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(predict_reply(c));
    items_sent++;
  endtask

  task automatic write_block(input logic [1:0] ch, input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      post_command(CMD_WRITE, ch, 8'($urandom), i == len - 1, 8'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic apply_layout(input logic [DESC_W-1:0] d0, input logic [DESC_W-1:0] d1,
                              input logic [DESC_W-1:0] d2, input logic [DESC_W-1:0] d3);
    logic [DESC_W-1:0] vals [4];
    vals = '{d0, d1, d2, d3};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= desc_reg_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      chan_desc[i]  = vals[i];
      slot_ptr[i]   = '0;
      fill_level[i] = '0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DESC_W-1:0] random_desc();
    if ($urandom_range(0, 7) == 0)
      return DESC_W'($urandom);
    return desc_value($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 1));
  endfunction

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at, base, nbytes, nblocks, held, len, pick;
    logic [1:0]  ch;
    logic [7:0]  entry;
    bit          ok;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 3));
      ok   = region_of(ch, base, nbytes, nblocks);
      held = held_blocks(ch);
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            len = $urandom_range(1, nbytes == 0 ? 3 : (nbytes < 6 ? nbytes : 6));
          9:       len = (nbytes <= 16) ? nbytes + $urandom_range(1, 2) : nbytes;
          default: len = (nbytes == 0) ? 1 : nbytes;
        endcase
        write_block(ch, len);
      end else if (pick < 80) begin
        if (ok && held != 0 && $urandom_range(0, 4) != 0) begin
          post_command(CMD_READ, ch, 8'($urandom), 1'($urandom),
                       8'($urandom_range(0, held - 1)), 8'($urandom_range(0, nbytes - 1)));
        end else begin
          entry = $urandom_range(0, 1) ? 8'(held) : 8'($urandom);
          post_command(CMD_READ, ch, 8'($urandom), 1'($urandom), entry, 8'($urandom));
        end
      end else if (pick < 85) begin
        post_command(CMD_CLEAR, ch, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        post_command(cmd_e'($urandom_range(0, 3)), ch, 8'($urandom), 1'($urandom),
                     8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic check_directed_cases();
    apply_layout(desc_value(2, 2, 0), desc_value(1, 2, 1), '0, desc_value(2, 1, 1));
    // older content for the short block below
    write_block(2'd0, 2);
    write_block(2'd0, 2);
    post_command(CMD_CLEAR, 2'd0, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_WRITE, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd0, 8'hFF, 1'b1, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd0, 8'hA5, 1'b1, 8'h00, 8'h00);  // short block
    post_command(CMD_WRITE, 2'd0, 8'h11, 1'b0, 8'h00, 8'h00);  // full, no overwrite
    post_command(CMD_WRITE, 2'd0, 8'h22, 1'b1, 8'h00, 8'h00);
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd1,   8'd1);  // older content past short end
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd2,   8'd0);
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd0,   8'd2);
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd255, 8'd255);
    post_command(CMD_WRITE, 2'd1, 8'h5A, 1'b1, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd1, 8'hC3, 1'b1, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd1, 8'h3C, 1'b1, 8'h00, 8'h00);  // replaces oldest
    post_command(CMD_READ,  2'd1, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_WRITE, 2'd3, 8'h01, 1'b0, 8'h00, 8'h00);  // channel switch mid-block
    post_command(CMD_WRITE, 2'd1, 8'h7E, 1'b1, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd3, 8'h10, 1'b0, 8'h00, 8'h00);  // overlong block
    post_command(CMD_WRITE, 2'd3, 8'h20, 1'b0, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd3, 8'h30, 1'b1, 8'h00, 8'h00);
    post_command(CMD_WRITE, 2'd2, 8'h99, 1'b1, 8'h00, 8'h00);  // disabled channel
    post_command(CMD_READ,  2'd2, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_CLEAR, 2'd2, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_CLEAR, 2'd0, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_READ,  2'd0, 8'h00, 1'b0, 8'd0,   8'd0);
    post_command(CMD_NOP,   2'd1, 8'hFF, 1'b1, 8'hFF, 8'hFF);
  endtask

  task automatic check_position_saturation();
    apply_layout(desc_value(255, 4, 1), desc_value(4, 1, 1), '1, '0);
    write_block(2'd1, 300);
    for (int i = 0; i < 5; i++)
      post_command(CMD_READ, 2'd1, 8'h00, 1'b0, 8'd0, 8'(i));
    random_traffic(80);
  endtask

  task automatic sweep_layouts();
    apply_layout(desc_value(4, 3, 0), desc_value(3, 2, 1), desc_value(1, 1, 1),
                 desc_value(8, 4, 0));
    random_traffic(120);
    apply_layout(desc_value(0, 5, 1), desc_value(5, 0, 0), desc_value(2, 255, 1),
                 desc_value(255, 2, 0));
    random_traffic(100);
    for (int i = 0; i < 4; i++) begin
      apply_layout(random_desc(), random_desc(), random_desc(), random_desc());
      random_traffic(80);
    end
  endtask

  task automatic run_back_to_back();
    idle_gaps = 1'b0;
    apply_layout(desc_value(3, 4, 1), desc_value(5, 2, 0), random_desc(), random_desc());
    random_traffic(200);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d with nothing pending", replies_seen));
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_seen, status_o, want.status));
        if (read_byte_o !== want.read_byte)
          report_mismatch($sformatf("reply %0d read_byte %02h, want %02h",
                                    replies_seen, read_byte_o, want.read_byte));
        if (stored_blocks_o !== want.stored_blocks)
          report_mismatch($sformatf("reply %0d stored_blocks %0d, want %0d",
                                    replies_seen, stored_blocks_o, want.stored_blocks));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("multi_channel_ring_log: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    cmd_i         <= CMD_NOP;
    channel_i     <= '0;
    data_byte_i   <= '0;
    last_byte_i   <= 1'b0;
    entry_i       <= '0;
    byte_offset_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_CHAN0_DESC;
    cfg_wdata_i   <= '0;
    for (int i = 0; i < 4; i++) begin
      chan_desc[i]  = '0;
      slot_ptr[i]   = '0;
      fill_level[i] = '0;
    end
    byte_pos    = '0;
    block_taken = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_directed_cases();
    check_position_saturation();
    sweep_layouts();
    run_back_to_back();
    settle();
    if (mismatches == 0)
      $display("multi_channel_ring_log: match");
    else
      $display("multi_channel_ring_log: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
